// ===== rtl/cbsq_pkg.sv =====
// ============================================================================
// cbsq_pkg
// Shared item types, mode codes, controller states, command and status
// structures, and helper functions for the codebook scalar quantiser.
// ============================================================================
package cbsq_pkg;

    localparam int CNT_W   = 9;   // entry count register, 1..256
    localparam int IDX_W   = 8;   // codebook index and code width ceiling
    localparam int VAL_W   = 16;  // signed Q8.8 values
    localparam int WORD_W  = 32;  // packing word
    localparam int PEND_W  = 6;   // bits held in the packing word
    localparam int CW_W    = 4;   // code width value, 1..8
    localparam int DIFF_W  = VAL_W + 1;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         entry_index;
        logic signed [VAL_W-1:0]  entry_value;
        logic signed [VAL_W-1:0]  sample_value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic              word_has_data;
        logic              end_of_stream;
        logic [WORD_W-1:0] samples_encoded;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_PACK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;          // write the codebook entry of the accepted item
        logic start;         // latch the sample and restart the search
        logic search;        // issue one codebook read
        logic pack_commit;   // fold the winning index into the packing word
        logic flush_commit;  // emit the flush result and clear the packer
    } t_dp_cmd;

    typedef struct packed {
        logic last_addr;     // the read being issued is the last entry in use
        logic pack_emit;     // packing the index produces a result
        logic out_free;      // the output register can take a result
    } t_dp_stat;

    // Code width from the number of entries in use.
    function automatic logic [CW_W-1:0] code_width(input logic [CNT_W-1:0] cnt);
        logic [CW_W-1:0] w;
        if (cnt <= CNT_W'(2)) begin
            w = CW_W'(1);
        end else if (cnt <= CNT_W'(4)) begin
            w = CW_W'(2);
        end else if (cnt <= CNT_W'(16)) begin
            w = CW_W'(4);
        end else begin
            w = CW_W'(8);
        end
        return w;
    endfunction

    // Left-justify a partial word so that the first code sits in the top bits.
    function automatic logic [WORD_W-1:0] justify(input logic [WORD_W-1:0] word,
                                                  input logic [PEND_W-1:0] pend);
        logic [WORD_W-1:0] res;
        if (pend == '0 || pend >= PEND_W'(WORD_W)) begin
            res = word;
        end else begin
            res = word << (PEND_W'(WORD_W) - pend);
        end
        return res;
    endfunction

endpackage

// ===== rtl/cbsq_ram.sv =====
// ============================================================================
// cbsq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module cbsq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cbsq_ctrl.sv =====
// ============================================================================
// cbsq_ctrl
// Sequencing state machine: accepts items, steps the codebook search and
// commits packing and flush results; one that emits waits for a free output.
// ============================================================================
module cbsq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    input  cbsq_pkg::t_dp_stat i_stat,
    output logic              o_in_stall,
    output cbsq_pkg::t_dp_cmd o_cmd
);

    import cbsq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign in_acc = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_mode == MODE_ENCODE) begin
                    n_state = ST_SEARCH;
                end else if (in_acc && i_mode == MODE_FLUSH) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_SEARCH: begin
                if (i_stat.last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_PACK;
            end
            ST_PACK: begin
                if (!i_stat.pack_emit || i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall         = (r_state != ST_IDLE);
        o_cmd              = '0;
        o_cmd.load         = in_acc && (i_mode == MODE_LOAD);
        o_cmd.start        = in_acc && (i_mode == MODE_ENCODE);
        o_cmd.search       = (r_state == ST_SEARCH);
        o_cmd.pack_commit  = (r_state == ST_PACK) && (!i_stat.pack_emit || i_stat.out_free);
        o_cmd.flush_commit = (r_state == ST_FLUSH) && i_stat.out_free;
    end

    a_search_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH && i_stat.last_addr) |=> (r_state == ST_DRAIN))
        else $error("search did not move to drain after the last entry");

    a_drain_packs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> (r_state == ST_PACK))
        else $error("drain not followed by pack");

endmodule

// ===== rtl/cbsq_dp.sv =====
// ============================================================================
// cbsq_dp
// Datapath: entry count register, codebook RAM, one-entry-per-cycle nearest
// search, MSB-first bit packer, sample counter and output register.
// ============================================================================
module cbsq_dp #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_wdata,
    input  cbsq_pkg::t_in_item  i_in_data,
    input  cbsq_pkg::t_dp_cmd   i_cmd,
    output cbsq_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output cbsq_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    import cbsq_pkg::*;

    // Only the first 256 slots can be addressed by an 8-bit index.
    localparam int DEPTH = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
    localparam int AW    = $clog2(DEPTH);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic signed [VAL_W-1:0] r_sample;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_rd_vld;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_have_best;
    logic [DIFF_W-1:0]       r_best_d;
    logic [IDX_W-1:0]        r_best_idx;
    logic [WORD_W-1:0]       r_word;
    logic [PEND_W-1:0]       r_pend;
    logic [WORD_W-1:0]       r_samples;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic                    slot_ok;
    logic signed [VAL_W-1:0] rd_val;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]       abs_d;
    logic                    better;
    logic [CW_W-1:0]         cw;
    logic [PEND_W:0]         sum;
    logic                    ovf;
    logic                    fill;
    logic [WORD_W-1:0]       shifted;
    logic [WORD_W-1:0]       pack_out;
    logic [WORD_W-1:0]       pack_word;
    logic [PEND_W-1:0]       pack_pend;

    // Entry count as used: zero reads as one, large values saturate.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_count = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > DEPTH) begin
            n_count = CNT_W'(DEPTH);
        end else begin
            n_count = i_cfg_wdata;
        end
    end

    assign slot_ok = (32'(i_in_data.entry_index) < MAX_ENTRIES);

    cbsq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_cbook (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && slot_ok),
        .i_waddr (i_in_data.entry_index[AW-1:0]),
        .i_wdata (i_in_data.entry_value),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_val)
    );

    // Distance of the entry returned this cycle; strict compare keeps the
    // lowest index on a tie since entries arrive in ascending order.
    always_comb begin
        diff   = DIFF_W'(r_sample) - DIFF_W'(rd_val);
        abs_d  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        better = !r_have_best || (abs_d < r_best_d);
    end

    // Packer update for the winning index.
    always_comb begin
        cw       = code_width(r_count);
        sum      = {1'b0, r_pend} + (PEND_W+1)'(cw);
        ovf      = sum > (PEND_W+1)'(WORD_W);
        fill     = sum == (PEND_W+1)'(WORD_W);
        shifted  = (r_word << cw) | WORD_W'(r_best_idx);
        pack_out = shifted;
        if (ovf) begin
            pack_out  = justify(r_word, r_pend);
            pack_word = WORD_W'(r_best_idx);
            pack_pend = PEND_W'(cw);
        end else if (fill) begin
            pack_word = '0;
            pack_pend = '0;
        end else begin
            pack_word = shifted;
            pack_pend = sum[PEND_W-1:0];
        end
    end

    always_comb begin
        o_stat.last_addr = (r_addr == r_count - CNT_W'(1));
        o_stat.pack_emit = ovf || fill;
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_W'(1);
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_word      <= '0;
            r_pend      <= '0;
            r_samples   <= '0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_count <= n_count;
            end
            r_rd_vld <= i_cmd.search;
            if (i_cmd.start) begin
                r_addr      <= '0;
                r_have_best <= 1'b0;
            end else if (i_cmd.search) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (r_rd_vld && better) begin
                r_have_best <= 1'b1;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.pack_commit) begin
                r_word    <= pack_word;
                r_pend    <= pack_pend;
                r_samples <= r_samples + WORD_W'(1);
                if (ovf || fill) begin
                    r_out_valid <= 1'b1;
                end
            end
            if (i_cmd.flush_commit) begin
                r_word      <= '0;
                r_pend      <= '0;
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sample <= i_in_data.sample_value;
        end
        r_rd_idx <= r_addr[IDX_W-1:0];
        if (r_rd_vld && better) begin
            r_best_d   <= abs_d;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.pack_commit && (ovf || fill)) begin
            r_out_data.packed_word     <= pack_out;
            r_out_data.word_has_data   <= 1'b1;
            r_out_data.end_of_stream   <= 1'b0;
            r_out_data.samples_encoded <= '0;
        end
        if (i_cmd.flush_commit) begin
            r_out_data.packed_word     <= justify(r_word, r_pend);
            r_out_data.word_has_data   <= (r_pend != '0);
            r_out_data.end_of_stream   <= 1'b1;
            r_out_data.samples_encoded <= r_samples;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_pend_below_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend < PEND_W'(WORD_W))
        else $error("packing word holds a full word without emitting it");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search |-> (r_addr < r_count))
        else $error("codebook read beyond the entries in use");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.pack_commit && (ovf || fill)) || i_cmd.flush_commit) |-> o_stat.out_free)
        else $error("result committed while the output register is held");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush_commit |=> (r_pend == '0 && r_word == '0))
        else $error("packer not cleared after flush");

endmodule

// ===== rtl/codebook_scalar_quantizer_packer.sv =====
// ============================================================================
// codebook_scalar_quantizer_packer
// Nearest-entry scalar quantiser over a loadable codebook with MSB-first
// packing of the winning indices into 32-bit words.
// ============================================================================
// An accepted encode reads each codebook entry in use in SEARCH, gets the last
// read in DRAIN and packs the index in PACK, giving a result only if the packing
// word fills or overflows; an accepted flush gives its result from FLUSH. Input
// stalls outside IDLE, so no encode or flush is taken until the last is through;
// loads and ignored items are taken one per cycle; held results delay the next.
// Sync active-low reset clears all but the RAM and data registers; count is one.
module codebook_scalar_quantizer_packer #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: the entry count register.
    input  logic                i_cfg_we,
    input  logic [8:0]          i_cfg_wdata,
    // Input item channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cbsq_pkg::t_in_item  i_in_data,
    // Result item channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cbsq_pkg::t_out_item o_out_data
);

    import cbsq_pkg::*;

    // The controller and datapath talk only through these two structures.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // The controller accepts an item only when idle. A load writes the
    // codebook in the acceptance cycle; an encode starts the linear search.
    cbsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the codebook, the search registers and the packer.
    // Its output register lets the next item be taken while a result waits.
    cbsq_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
